// ----- src/dra_pkg.sv -----
// ----------------------------------------------------------------------------
// dra_pkg
// Types and constants shared by the DNS response address parser.
// ----------------------------------------------------------------------------
package dra_pkg;

    typedef struct packed {
        logic [7:0] response_byte;
        logic       last_byte;
    } dra_in_t;

    typedef struct packed {
        logic        lookup_ok;
        logic [31:0] ip_address;
    } dra_out_t;

    typedef enum logic [12:0] {
        PH_HEADER    = 13'b0000000000001,
        PH_QNAME     = 13'b0000000000010,
        PH_QSKIP     = 13'b0000000000100,
        PH_QPTR      = 13'b0000000001000,
        PH_QFIXED    = 13'b0000000010000,
        PH_ANAME     = 13'b0000000100000,
        PH_ASKIP     = 13'b0000001000000,
        PH_APTR      = 13'b0000010000000,
        PH_ATYPE     = 13'b0000100000000,
        PH_ACLASSTTL = 13'b0001000000000,
        PH_RDLEN     = 13'b0010000000000,
        PH_ADDR      = 13'b0100000000000,
        PH_DONE      = 13'b1000000000000
    } dra_phase_t;

    localparam logic [3:0]  HDR_FLAGS_HI  = 4'd2;
    localparam logic [3:0]  HDR_FLAGS_LO  = 4'd3;
    localparam logic [3:0]  HDR_ANCOUNT_HI = 4'd6;
    localparam logic [3:0]  HDR_ANCOUNT_LO = 4'd7;
    localparam logic [3:0]  HDR_LAST      = 4'd11;
    localparam logic [7:0]  QR_MASK       = 8'h80;
    localparam logic [7:0]  RCODE_MASK    = 8'h0F;
    localparam logic [7:0]  PTR_MASK      = 8'hC0;
    localparam logic [7:0]  QFIXED_LEN    = 8'd4;
    localparam logic [7:0]  ATYPE_LEN     = 8'd2;
    localparam logic [7:0]  CLASSTTL_LEN  = 8'd6;
    localparam logic [7:0]  RDLEN_LEN     = 8'd2;
    localparam logic [15:0] TYPE_A        = 16'd1;
    localparam logic [15:0] ADDR_LEN      = 16'd4;
    localparam logic [2:0]  ADDR_BYTES    = 3'd4;

endpackage

// ----- src/dns_response_address_parser_top.sv -----
// ----------------------------------------------------------------------------
// dns_response_address_parser_top
// Parses a DNS response byte stream and returns the first answer's IPv4
// address.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one datagram byte per item, last_byte set on
//   the final byte. One byte is taken every cycle while s_ready is high.
//   Each byte updates the parse state in the cycle it is accepted; the final
//   byte also loads the result register, so m_valid rises in the cycle after
//   the last byte is accepted.
//   m_data.lookup_ok is 1 only for a clean response whose first answer is
//   type A with a 4-byte address; on failure ip_address is zero.
//   After the final byte the parser returns to its start state, so the next
//   datagram may follow immediately.
//   If the receiver stalls, the result is held in the output register and
//   input bytes keep flowing; s_ready drops only when a result is held and
//   another final byte would need the register.
//   Reset (aresetn low, synchronous) returns the parser to the header phase
//   and empties the output register.
// ----------------------------------------------------------------------------
module dns_response_address_parser_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dra_pkg::dra_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dra_pkg::dra_out_t m_data
);
    import dra_pkg::*;

    dra_phase_t  phase_reg,  phase_next;
    logic [3:0]  hpos_reg,   hpos_next;
    logic [7:0]  skip_reg,   skip_next;
    logic [7:0]  ancnt_hi_reg, ancnt_hi_next;
    logic        failed_reg, failed_next;
    logic [15:0] rtype_reg,  rtype_next;
    logic [15:0] rdlen_reg,  rdlen_next;
    logic [31:0] addr_reg,   addr_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    logic        m_valid_reg;
    dra_out_t    m_data_reg;
    logic        accept;
    logic [7:0]  b;
    logic [7:0]  skip_dec;
    logic        ok;

    assign b        = s_data.response_byte;
    assign skip_dec = skip_reg - 8'd1;
    assign s_ready  = !m_valid_reg || m_ready || !s_data.last_byte;
    assign accept   = s_valid && s_ready;

    always_comb begin
        phase_next    = phase_reg;
        hpos_next     = hpos_reg;
        skip_next     = skip_reg;
        ancnt_hi_next = ancnt_hi_reg;
        failed_next   = failed_reg;
        rtype_next    = rtype_reg;
        rdlen_next    = rdlen_reg;
        addr_next     = addr_reg;
        nbytes_next   = nbytes_reg;
        if (!failed_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hpos_reg == HDR_FLAGS_HI) begin
                        if ((b & QR_MASK) == 8'h00) failed_next = 1'b1;
                    end else if (hpos_reg == HDR_FLAGS_LO) begin
                        if ((b & RCODE_MASK) != 8'h00) failed_next = 1'b1;
                    end else if (hpos_reg == HDR_ANCOUNT_HI) begin
                        ancnt_hi_next = b;
                    end else if (hpos_reg == HDR_ANCOUNT_LO) begin
                        if (ancnt_hi_reg == 8'h00 && b == 8'h00) failed_next = 1'b1;
                    end
                    if (hpos_reg >= HDR_LAST) begin
                        hpos_next  = 4'd0;
                        phase_next = PH_QNAME;
                    end else begin
                        hpos_next = hpos_reg + 4'd1;
                    end
                end
                PH_QNAME, PH_ANAME: begin
                    if (b == 8'h00) begin
                        phase_next = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_ATYPE;
                        skip_next  = (phase_reg == PH_QNAME) ? QFIXED_LEN : ATYPE_LEN;
                    end else if ((b & PTR_MASK) == PTR_MASK) begin
                        phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                    end else begin
                        phase_next = (phase_reg == PH_QNAME) ? PH_QSKIP : PH_ASKIP;
                        skip_next  = b;
                    end
                end
                PH_QSKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0) phase_next = PH_QNAME;
                end
                PH_QPTR: begin
                    phase_next = PH_QFIXED;
                    skip_next  = QFIXED_LEN;
                end
                PH_QFIXED: begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0) phase_next = PH_ANAME;
                end
                PH_ASKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0) phase_next = PH_ANAME;
                end
                PH_APTR: begin
                    phase_next = PH_ATYPE;
                    skip_next  = ATYPE_LEN;
                end
                PH_ATYPE: begin
                    rtype_next = {rtype_reg[7:0], b};
                    skip_next  = skip_dec;
                    if (skip_dec == 8'd0) begin
                        phase_next = PH_ACLASSTTL;
                        skip_next  = CLASSTTL_LEN;
                    end
                end
                PH_ACLASSTTL: begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0) begin
                        phase_next = PH_RDLEN;
                        skip_next  = RDLEN_LEN;
                    end
                end
                PH_RDLEN: begin
                    rdlen_next = {rdlen_reg[7:0], b};
                    skip_next  = skip_dec;
                    if (skip_dec == 8'd0) begin
                        if (rtype_reg != TYPE_A || rdlen_next != ADDR_LEN)
                            failed_next = 1'b1;
                        else
                            phase_next = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    addr_next   = {addr_reg[23:0], b};
                    nbytes_next = nbytes_reg + 3'd1;
                    if (nbytes_next >= ADDR_BYTES) phase_next = PH_DONE;
                end
                PH_DONE: ;
                default: failed_next = 1'b1;
            endcase
        end
    end

    assign ok = !failed_next && (phase_next == PH_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hpos_reg     <= '0;
            skip_reg     <= '0;
            ancnt_hi_reg <= '0;
            failed_reg   <= 1'b0;
            rtype_reg    <= '0;
            rdlen_reg    <= '0;
            addr_reg     <= '0;
            nbytes_reg   <= '0;
        end else if (accept) begin
            if (s_data.last_byte) begin
                phase_reg    <= PH_HEADER;
                hpos_reg     <= '0;
                skip_reg     <= '0;
                ancnt_hi_reg <= '0;
                failed_reg   <= 1'b0;
                rtype_reg    <= '0;
                rdlen_reg    <= '0;
                addr_reg     <= '0;
                nbytes_reg   <= '0;
            end else begin
                phase_reg    <= phase_next;
                hpos_reg     <= hpos_next;
                skip_reg     <= skip_next;
                ancnt_hi_reg <= ancnt_hi_next;
                failed_reg   <= failed_next;
                rtype_reg    <= rtype_next;
                rdlen_reg    <= rdlen_next;
                addr_reg     <= addr_next;
                nbytes_reg   <= nbytes_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_data.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_data.last_byte) begin
            m_data_reg.lookup_ok  <= ok;
            m_data_reg.ip_address <= ok ? addr_next : 32'd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/dra_checker.sv -----
// ----------------------------------------------------------------------------
// dra_checker
// Port-level checks for the DNS response address parser.
// ----------------------------------------------------------------------------
module dra_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input dra_pkg::dra_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input dra_pkg::dra_out_t m_data
);
    import dra_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.lookup_ok |-> m_data.ip_address == 32'd0)
        else $error("failed lookup carries an address");

    a_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && $past(!m_valid || m_ready)
            |-> $past(s_valid && s_ready && s_data.last_byte))
        else $error("result without a final byte");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind dns_response_address_parser_top dra_checker u_dra_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/tb_dns_response_address_parser_top.sv -----
// ----------------------------------------------------------------------------
// tb_dns_response_address_parser_top
// Sends DNS response datagrams one byte per item and checks each lookup
// result against a byte-level parser model kept in a scoreboard. Frames are
// mostly well formed with random content. Others are cut short, corrupted,
// or pure noise. The sender idles in bursts and the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module tb_dns_response_address_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dra_pkg::*;

    class addr_lookup_scoreboard;
        dra_phase_t  phase;
        logic [3:0]  hdr_pos;
        logic [7:0]  skip_cnt;
        logic [7:0]  flags_hi;
        logic [7:0]  ancount_hi;
        logic        failed;
        logic [15:0] rec_type;
        logic [15:0] rec_len;
        logic [31:0] addr_acc;
        logic [2:0]  addr_cnt;
        dra_out_t    expected_lookups[$];
        int          errors;

        function new();
            errors = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase      = PH_HEADER;
            hdr_pos    = '0;
            skip_cnt   = '0;
            flags_hi   = '0;
            ancount_hi = '0;
            failed     = 1'b0;
            rec_type   = '0;
            rec_len    = '0;
            addr_acc   = '0;
            addr_cnt   = '0;
        endfunction

        function void name_len(logic [7:0] b, dra_phase_t skip_ph, dra_phase_t ptr_ph,
                               dra_phase_t end_ph, logic [7:0] end_cnt);
            if (b == 8'h00) begin
                phase    = end_ph;
                skip_cnt = end_cnt;
            end else if ((b & PTR_MASK) == PTR_MASK) begin
                phase = ptr_ph;
            end else begin
                phase    = skip_ph;
                skip_cnt = b;
            end
        endfunction

        function void parse_byte(logic [7:0] b);
            if (failed)
                return;
            case (phase)
                PH_HEADER: begin
                    if (hdr_pos == HDR_FLAGS_HI) begin
                        flags_hi = b;
                        if ((flags_hi & QR_MASK) == 8'h00)
                            failed = 1'b1;
                    end else if (hdr_pos == HDR_FLAGS_LO) begin
                        if ((b & RCODE_MASK) != 8'h00)
                            failed = 1'b1;
                    end else if (hdr_pos == HDR_ANCOUNT_HI) begin
                        ancount_hi = b;
                    end else if (hdr_pos == HDR_ANCOUNT_LO) begin
                        if (ancount_hi == 8'h00 && b == 8'h00)
                            failed = 1'b1;
                    end
                    if (hdr_pos >= HDR_LAST) begin
                        hdr_pos = '0;
                        phase   = PH_QNAME;
                    end else begin
                        hdr_pos = hdr_pos + 4'd1;
                    end
                end
                PH_QNAME: name_len(b, PH_QSKIP, PH_QPTR, PH_QFIXED, QFIXED_LEN);
                PH_QSKIP: begin
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'h00)
                        phase = PH_QNAME;
                end
                PH_QPTR: begin
                    phase    = PH_QFIXED;
                    skip_cnt = QFIXED_LEN;
                end
                PH_QFIXED: begin
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'h00)
                        phase = PH_ANAME;
                end
                PH_ANAME: name_len(b, PH_ASKIP, PH_APTR, PH_ATYPE, ATYPE_LEN);
                PH_ASKIP: begin
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'h00)
                        phase = PH_ANAME;
                end
                PH_APTR: begin
                    phase    = PH_ATYPE;
                    skip_cnt = ATYPE_LEN;
                end
                PH_ATYPE: begin
                    rec_type = {rec_type[7:0], b};
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'h00) begin
                        phase    = PH_ACLASSTTL;
                        skip_cnt = CLASSTTL_LEN;
                    end
                end
                PH_ACLASSTTL: begin
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'h00) begin
                        phase    = PH_RDLEN;
                        skip_cnt = RDLEN_LEN;
                    end
                end
                PH_RDLEN: begin
                    rec_len  = {rec_len[7:0], b};
                    skip_cnt = skip_cnt - 8'd1;
                    if (skip_cnt == 8'h00) begin
                        if (rec_type != TYPE_A || rec_len != ADDR_LEN)
                            failed = 1'b1;
                        else
                            phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    addr_acc = {addr_acc[23:0], b};
                    addr_cnt = addr_cnt + 3'd1;
                    if (addr_cnt >= ADDR_BYTES)
                        phase = PH_DONE;
                end
                PH_DONE: ;
                default: failed = 1'b1;
            endcase
        endfunction

        function void note_byte(dra_in_t item);
            dra_out_t res;
            parse_byte(item.response_byte);
            if (item.last_byte) begin
                res.lookup_ok  = !failed && phase == PH_DONE;
                res.ip_address = res.lookup_ok ? addr_acc : 32'h0;
                expected_lookups.push_back(res);
                clear_parse();
            end
        endfunction

        function void check_result(dra_out_t got);
            dra_out_t want;
            if (expected_lookups.size() == 0) begin
                $error("unexpected result: lookup_ok %0b ip_address %08h",
                       got.lookup_ok, got.ip_address);
                errors++;
                return;
            end
            want = expected_lookups.pop_front();
            if (got.lookup_ok !== want.lookup_ok) begin
                $error("lookup_ok: expected %0b, got %0b", want.lookup_ok, got.lookup_ok);
                errors++;
            end
            if (got.ip_address !== want.ip_address) begin
                $error("ip_address: expected %08h, got %08h", want.ip_address, got.ip_address);
                errors++;
            end
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction
    endclass

    typedef struct {
        logic [7:0]  flags_hi;
        logic [7:0]  flags_lo;
        logic [15:0] ancount;
        int          qname_labels;
        bit          qname_ptr;
        int          aname_labels;
        bit          aname_ptr;
        int          label_fixed;
        logic [15:0] rec_type;
        logic [15:0] rec_len;
        logic [31:0] addr;
        int          trailing;
        int          cut_len;
        int          drop_tail;
    } frame_spec_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    dra_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    dra_out_t m_data;

    addr_lookup_scoreboard sb;
    logic [7:0] frame[$];
    int burst_left;
    int bytes_sent;

    dns_response_address_parser_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("[dns_response_address_parser_top] ERROR");
        $finish;
    end

    function automatic void push_name(int labels, bit ptr, int fixed_len);
        int len;
        for (int i = 0; i < labels; i++) begin
            if (fixed_len != 0)
                len = fixed_len;
            else if ($urandom_range(0, 19) == 0)
                len = $urandom_range(64, 191);
            else
                len = $urandom_range(1, 12);
            frame.push_back(8'(len));
            repeat (len) frame.push_back(8'($urandom));
        end
        if (ptr) begin
            frame.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
            frame.push_back(8'($urandom));
        end else begin
            frame.push_back(8'h00);
        end
    endfunction

    function automatic void build_frame(frame_spec_t s);
        frame.delete();
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(s.flags_hi);
        frame.push_back(s.flags_lo);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(s.ancount[15:8]);
        frame.push_back(s.ancount[7:0]);
        repeat (4) frame.push_back(8'($urandom));
        push_name(s.qname_labels, s.qname_ptr, s.label_fixed);
        repeat (4) frame.push_back(8'($urandom));
        push_name(s.aname_labels, s.aname_ptr, s.label_fixed);
        frame.push_back(s.rec_type[15:8]);
        frame.push_back(s.rec_type[7:0]);
        repeat (6) frame.push_back(8'($urandom));
        frame.push_back(s.rec_len[15:8]);
        frame.push_back(s.rec_len[7:0]);
        for (int i = 3; i >= 0; i--)
            frame.push_back(s.addr[8*i +: 8]);
        repeat (s.trailing) frame.push_back(8'($urandom));
        if (s.cut_len > 0)
            while (frame.size() > s.cut_len) frame.pop_back();
        repeat (s.drop_tail) frame.pop_back();
    endfunction

    function automatic frame_spec_t good_spec();
        frame_spec_t s;
        s.flags_hi     = QR_MASK | 8'h01;
        s.flags_lo     = 8'h80;
        s.ancount      = 16'd1;
        s.qname_labels = 1;
        s.qname_ptr    = 1'b0;
        s.aname_labels = 0;
        s.aname_ptr    = 1'b1;
        s.label_fixed  = 0;
        s.rec_type     = TYPE_A;
        s.rec_len      = ADDR_LEN;
        s.addr         = $urandom;
        s.trailing     = 0;
        s.cut_len      = 0;
        s.drop_tail    = 0;
        return s;
    endfunction

    function automatic frame_spec_t random_spec();
        frame_spec_t s;
        s = good_spec();
        s.flags_hi = ($urandom_range(0, 19) == 0) ? 8'($urandom) : (8'($urandom) | QR_MASK);
        s.flags_lo = ($urandom_range(0, 19) == 0) ? 8'($urandom) : (8'($urandom) & ~RCODE_MASK);
        s.ancount  = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        s.qname_labels = $urandom_range(0, 3);
        s.qname_ptr    = 1'($urandom_range(0, 1));
        s.aname_labels = $urandom_range(0, 2);
        s.aname_ptr    = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 14) == 0)
            s.rec_type = 16'($urandom);
        if ($urandom_range(0, 14) == 0)
            s.rec_len = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            s.trailing = $urandom_range(1, 4);
        return s;
    endfunction

    task automatic send_byte(input dra_in_t item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(item);
        bytes_sent++;
    endtask

    task automatic send_frame();
        dra_in_t item;
        for (int i = 0; i < frame.size(); i++) begin
            item.response_byte = frame[i];
            item.last_byte     = (i == frame.size() - 1);
            send_byte(item);
        end
    endtask

    task automatic send_spec(input frame_spec_t s);
        build_frame(s);
        send_frame();
    endtask

    // receiver: all-ready, random, sparse, and full-stall stretches
    initial begin
        int mode;
        int len;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = (mode == 3) ? $urandom_range(1, 25) : $urandom_range(20, 120);
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    initial begin
        frame_spec_t s;
        int kind;
        int idx;
        sb = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        burst_left  = 0;
        bytes_sent  = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames
        s = good_spec();
        s.flags_hi = 8'hFF; s.flags_lo = 8'hF0; s.ancount = 16'hFFFF;
        s.addr = 32'hFFFF_FFFF;
        send_spec(s);
        s = good_spec();
        s.flags_hi = QR_MASK; s.flags_lo = 8'h00; s.qname_labels = 0; s.qname_ptr = 1'b1;
        s.aname_labels = 2; s.aname_ptr = 1'b0; s.addr = 32'h0; s.trailing = 3;
        send_spec(s);
        s = good_spec(); s.cut_len = 1;            send_spec(s);
        s = good_spec(); s.cut_len = 12;           send_spec(s);
        s = good_spec(); s.flags_hi = 8'h7F;       send_spec(s);
        s = good_spec(); s.flags_lo = 8'h0F;       send_spec(s);
        s = good_spec(); s.ancount = 16'h0000;     send_spec(s);
        s = good_spec(); s.ancount = 16'h0100;     send_spec(s);
        s = good_spec(); s.rec_type = 16'h0101;    send_spec(s);
        s = good_spec(); s.rec_len = 16'h0104;     send_spec(s);
        s = good_spec(); s.drop_tail = 1;          send_spec(s);
        s = good_spec(); s.label_fixed = 8'h40;    send_spec(s);
        s = good_spec();
        s.label_fixed = 8'h80; s.qname_labels = 0; s.qname_ptr = 1'b1;
        s.aname_labels = 1; s.aname_ptr = 1'b0;
        send_spec(s);

        // random frames: mostly well formed, some cut, corrupted or noise
        while (bytes_sent < 1350) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                frame.delete();
                repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
            end else begin
                build_frame(random_spec());
                if (kind < 25) begin
                    idx = $urandom_range(1, frame.size());
                    while (frame.size() > idx) frame.pop_back();
                end else if (kind < 35) begin
                    idx = $urandom_range(0, frame.size() - 1);
                    frame[idx] = 8'($urandom);
                end
            end
            send_frame();
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.errors == 0)
            $display("[dns_response_address_parser_top] OK");
        else
            $display("[dns_response_address_parser_top] ERROR");
        $finish;
    end

endmodule
